// ----- hdl/pcxrle_pkg.sv -----
// Shared types and constants of the PCX run-length palette decoder.
package pcxrle_pkg;

   // Input item kinds.
   localparam logic CMD_PALETTE_WRITE = 1'b0;
   localparam logic CMD_CODE_BYTE     = 1'b1;

   // Register indexes, taken from the word address of the configuration port.
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [14:0] WIDTH_RESET  = 15'd320;
   localparam logic [14:0] HEIGHT_RESET = 15'd200;

   localparam logic [7:0]  RUN_THRESHOLD = 8'hBF;
   localparam logic [7:0]  RUN_MASK      = 8'h3F;
   localparam logic [14:0] SIZE_MAX_REG  = 15'd16384;
   localparam logic [27:0] COUNT_MAX     = 28'h0FFFFFFF;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_item;
      logic write_palette;
      logic arm_run;
      logic start_count;
      logic emit_pixel;
   } pcxrle_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic item_is_write;
      logic image_full;
      logic run_armed;
      logic code_is_run;
      logic count_zero;
      logic slot_free;
      logic last_of_run;
   } pcxrle_status_type;

endpackage

// ----- hdl/pcx_rle_palette_decoder.sv -----
// Top level of the PCX run-length palette decoder with its configuration registers.
//
// Request channel (req_): one word is either a palette write (req_cmd = 0, entry
// req_palette_index gets req_palette_rgb) or one encoded image byte (req_cmd = 1).
// Response channel (rsp_): one word per decoded pixel with its RGB colour, a flag on
// the last pixel caused by a request word and a flag on the final pixel of the image.
// Configuration: image_width at byte address 0, image_height at 4, to be written only
// while the decoder is idle; the block itself does not enforce this.
// A palette write is stored in the cycle it is taken. A code byte is taken, then
// decoded in the next cycle while its palette entry comes out of the registered
// memory read; a run header only arms the run, a literal or run byte goes on to emit
// its N pixels, one per cycle unless the response stalls. The controller works on
// one word at a time. A stalled response holds the output register and the
// controller waits, so the request side stalls too. Reset clears the run and pixel
// count and restores the default 320 x 200 size; palette entries hold nothing until
// written. Once the image is complete, code bytes are taken and dropped until the
// next reset or until a larger image size is written.
module pcx_rle_palette_decoder import pcxrle_pkg::*; #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_palette_index,
   input  logic [23:0] req_palette_rgb,
   input  logic [7:0]  req_code_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_run_last,
   output logic        rsp_image_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [14:0]       width_ff, height_ff;
   logic              csr_write;
   pcxrle_cmd_type    cmd;
   pcxrle_status_type status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_IMAGE_WIDTH:  width_ff  <= pwdata[14:0];
            REG_IMAGE_HEIGHT: height_ff <= pwdata[14:0];
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_IMAGE_WIDTH:  prdata = {17'd0, width_ff};
         REG_IMAGE_HEIGHT: prdata = {17'd0, height_ff};
         default:          prdata = 32'd0;
      endcase
   end

   pcxrle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pcxrle_datapath #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .image_width       (width_ff),
      .image_height      (height_ff),
      .req_cmd           (req_cmd),
      .req_palette_index (req_palette_index),
      .req_palette_rgb   (req_palette_rgb),
      .req_code_byte     (req_code_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_run_last      (rsp_run_last),
      .rsp_image_last    (rsp_image_last)
   );

endmodule

// ----- hdl/pcxrle_ctrl.sv -----
// Controller state machine of the PCX run-length palette decoder.
module pcxrle_ctrl import pcxrle_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pcxrle_status_type status,
   output pcxrle_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take_item = req_valid && !stall_ff;
            if (cmd.take_item) begin
               if (status.item_is_write) begin
                  cmd.write_palette = 1'b1;
               end else begin
                  state_in = ST_DECODE;
               end
            end
         end
         ST_DECODE: begin
            if (status.image_full) begin
               state_in = ST_IDLE;
            end else if (status.run_armed) begin
               cmd.start_count = 1'b1;
               state_in = status.count_zero ? ST_IDLE : ST_EMIT;
            end else if (status.code_is_run) begin
               cmd.arm_run = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.start_count = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit_pixel = 1'b1;
               if (status.last_of_run) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      stall_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

// ----- hdl/pcxrle_datapath.sv -----
// Datapath of the PCX run-length palette decoder: palette memory, counters and output word.
module pcxrle_datapath import pcxrle_pkg::*; #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [14:0]       image_width,
   input  logic [14:0]       image_height,
   input  logic              req_cmd,
   input  logic [7:0]        req_palette_index,
   input  logic [23:0]       req_palette_rgb,
   input  logic [7:0]        req_code_byte,
   input  pcxrle_cmd_type    cmd,
   output pcxrle_status_type status,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic              rsp_run_last,
   output logic              rsp_image_last
);

   localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   logic [23:0] palette_mem [PALETTE_ENTRIES];
   logic [23:0] pal_rd_ff;
   logic        pal_wr_ok;

   logic [7:0]  byte_ff;
   logic        oor_ff;
   logic [27:0] total_ff, total_in;
   logic [14:0] width_clamp, height_clamp;
   logic [29:0] product;
   logic [27:0] remain;
   logic [5:0]  run_clamped;
   logic [7:0]  code_masked;

   logic        run_armed_ff, run_armed_in;
   logic [5:0]  run_length_ff, run_length_in;
   logic [27:0] pixels_done_ff, pixels_done_in;
   logic [5:0]  count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] colour;
   logic [23:0] rgb_ff;
   logic        run_last_ff, image_last_ff;

   assign pal_wr_ok = ({1'b0, req_palette_index} < 9'(PALETTE_ENTRIES));

   always_ff @(posedge clock) begin
      if (cmd.write_palette && pal_wr_ok) begin
         palette_mem[req_palette_index[PAL_AW-1:0]] <= req_palette_rgb;
      end
      if (cmd.take_item) begin
         pal_rd_ff <= palette_mem[req_code_byte[PAL_AW-1:0]];
      end
   end

   // The pixel total follows the size registers in the cycle after they change.
   always_comb begin
      width_clamp  = (image_width  > SIZE_MAX_REG) ? SIZE_MAX_REG : image_width;
      height_clamp = (image_height > SIZE_MAX_REG) ? SIZE_MAX_REG : image_height;
      product      = 30'(width_clamp) * 30'(height_clamp);
      total_in     = (product > {2'b00, COUNT_MAX}) ? COUNT_MAX : product[27:0];
   end

   always_comb begin
      remain      = total_ff - pixels_done_ff;
      run_clamped = ({22'd0, run_length_ff} > remain) ? remain[5:0] : run_length_ff;
      code_masked = byte_ff & RUN_MASK;
      colour      = oor_ff ? 24'd0 : pal_rd_ff;

      run_armed_in   = run_armed_ff;
      run_length_in  = run_length_ff;
      pixels_done_in = pixels_done_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (cmd.arm_run) begin
         run_armed_in  = 1'b1;
         run_length_in = code_masked[5:0];
      end
      if (cmd.start_count) begin
         count_in      = run_armed_ff ? run_clamped : 6'd1;
         run_armed_in  = 1'b0;
         run_length_in = 6'd0;
      end
      if (cmd.emit_pixel) begin
         count_in       = count_ff - 6'd1;
         pixels_done_in = pixels_done_ff + 28'd1;
         rsp_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      count_ff <= count_in;
      if (cmd.take_item) begin
         byte_ff <= req_code_byte;
         oor_ff  <= ({1'b0, req_code_byte} >= 9'(PALETTE_ENTRIES));
      end
      if (cmd.emit_pixel) begin
         rgb_ff        <= colour;
         run_last_ff   <= (count_ff == 6'd1);
         image_last_ff <= ((pixels_done_ff + 28'd1) == total_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_armed_ff   <= 1'b0;
         run_length_ff  <= 6'd0;
         pixels_done_ff <= 28'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         run_armed_ff   <= run_armed_in;
         run_length_ff  <= run_length_in;
         pixels_done_ff <= pixels_done_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_comb begin
      status.item_is_write = (req_cmd == CMD_PALETTE_WRITE);
      status.image_full    = (pixels_done_ff >= total_ff);
      status.run_armed     = run_armed_ff;
      status.code_is_run   = (byte_ff > RUN_THRESHOLD);
      status.count_zero    = run_armed_ff && (run_clamped == 6'd0);
      status.slot_free     = !rsp_valid_ff || !rsp_stall;
      status.last_of_run   = (count_ff == 6'd1);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = rgb_ff[23:16];
   assign rsp_green      = rgb_ff[15:8];
   assign rsp_blue       = rgb_ff[7:0];
   assign rsp_run_last   = run_last_ff;
   assign rsp_image_last = image_last_ff;

endmodule
